@@ sv/cdq_pkg.sv @@
package cdq_pkg;

   // Element width and default ring depth
   localparam int DATA_W        = 32;
   localparam int DEPTH_DEFAULT = 16;

   // Value reported for a missing element
   localparam logic [DATA_W-1:0] NEG_ONE = '1;

   // Request operation codes
   typedef enum logic [1:0] {
      MODE_PUSH_FRONT = 2'd0,
      MODE_PUSH_BACK  = 2'd1,
      MODE_POP_FRONT  = 2'd2,
      MODE_POP_BACK   = 2'd3
   } mode_type;

endpackage

@@ sv/cdq_mem.sv @@
module cdq_mem #(
   parameter int DEPTH = cdq_pkg::DEPTH_DEFAULT,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [AW-1:0]              wr_addr,
   input  logic [cdq_pkg::DATA_W-1:0] wr_data,
   input  logic                       rd_en,
   input  logic [AW-1:0]              rd_addr,
   output logic [cdq_pkg::DATA_W-1:0] rd_data
);

   logic [cdq_pkg::DATA_W-1:0] mem_ff [DEPTH];
   logic [cdq_pkg::DATA_W-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/circular_deque.sv @@
// Double-ended queue of DEPTH signed 32-bit words kept in a ring memory.
// Each request pushes req_value at the front or back, or pops from either
// end, and returns one response with the popped value, the front and back
// elements after the operation, the occupancy and the empty, full and fault
// flags. A push on a full deque is dropped and a pop on an empty deque
// returns -1; both set fault and leave the contents unchanged. Front and back
// elements are held in registers next to the memory. A pop that leaves at
// least one element passes through ST_FILL, since the new end element
// comes from the registered memory read port. A new request is taken
// while the previous response is accepted in the same cycle. There is no
// clearing pass after reset.
module circular_deque #(
   parameter int DEPTH = cdq_pkg::DEPTH_DEFAULT,
   parameter int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   parameter int CW    = $clog2(DEPTH + 1)
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [1:0]                        req_mode,
   input  logic signed [cdq_pkg::DATA_W-1:0] req_value,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic signed [cdq_pkg::DATA_W-1:0] rsp_popped_value,
   output logic signed [cdq_pkg::DATA_W-1:0] rsp_front_value,
   output logic signed [cdq_pkg::DATA_W-1:0] rsp_back_value,
   output logic [CW-1:0]                     rsp_occupancy,
   output logic                              rsp_is_empty,
   output logic                              rsp_is_full,
   output logic                              rsp_fault
);

   localparam logic [PW-1:0] PtrLast = PW'(DEPTH - 1);
   localparam logic [CW-1:0] CntFull = CW'(DEPTH);

   typedef enum logic {
      ST_IDLE,
      ST_FILL
   } state_type;

   state_type state_ff, state_in;
   logic [PW-1:0] head_ff, head_in;
   logic [PW-1:0] tail_ff, tail_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [cdq_pkg::DATA_W-1:0] front_ff, front_in;
   logic [cdq_pkg::DATA_W-1:0] back_ff, back_in;
   logic side_front_ff, side_front_in;

   logic rsp_valid_ff, rsp_valid_in;
   logic [cdq_pkg::DATA_W-1:0] rsp_popped_ff, rsp_popped_in;
   logic [cdq_pkg::DATA_W-1:0] rsp_front_ff, rsp_front_in;
   logic [cdq_pkg::DATA_W-1:0] rsp_back_ff, rsp_back_in;
   logic [CW-1:0] rsp_occ_ff, rsp_occ_in;
   logic rsp_fault_ff, rsp_fault_in;

   logic wr_en;
   logic [PW-1:0] wr_addr;
   logic rd_en;
   logic [PW-1:0] rd_addr;
   logic [cdq_pkg::DATA_W-1:0] rd_data;

   // Ring pointer steps, wrapping at DEPTH
   function automatic logic [PW-1:0] ptr_up(input logic [PW-1:0] p);
      return (p == PtrLast) ? '0 : p + 1'b1;
   endfunction

   function automatic logic [PW-1:0] ptr_down(input logic [PW-1:0] p);
      return (p == '0) ? PtrLast : p - 1'b1;
   endfunction

   cdq_mem #(
      .DEPTH (DEPTH),
      .AW    (PW)
   ) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_value),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Take a request when idle and the response register frees up
   assign req_ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ready);

   // Operation decode and next state
   always_comb begin
      state_in      = state_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      cnt_in        = cnt_ff;
      front_in      = front_ff;
      back_in       = back_ff;
      side_front_in = side_front_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_popped_in = rsp_popped_ff;
      rsp_front_in  = rsp_front_ff;
      rsp_back_in   = rsp_back_ff;
      rsp_occ_in    = rsp_occ_ff;
      rsp_fault_in  = rsp_fault_ff;
      wr_en         = 1'b0;
      wr_addr       = '0;
      rd_en         = 1'b0;
      rd_addr       = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_ready) begin
               rsp_popped_in = cdq_pkg::NEG_ONE;
               rsp_fault_in  = 1'b0;
               rsp_valid_in  = 1'b1;
               case (cdq_pkg::mode_type'(req_mode))
                  cdq_pkg::MODE_PUSH_FRONT, cdq_pkg::MODE_PUSH_BACK: begin
                     if (cnt_ff == CntFull) begin
                        rsp_fault_in = 1'b1;
                     end else if (cnt_ff == '0) begin
                        // first element lands in slot zero
                        head_in  = '0;
                        tail_in  = '0;
                        wr_en    = 1'b1;
                        wr_addr  = '0;
                        front_in = req_value;
                        back_in  = req_value;
                        cnt_in   = cnt_ff + 1'b1;
                     end else if (req_mode == cdq_pkg::MODE_PUSH_FRONT) begin
                        head_in  = ptr_down(head_ff);
                        wr_en    = 1'b1;
                        wr_addr  = ptr_down(head_ff);
                        front_in = req_value;
                        cnt_in   = cnt_ff + 1'b1;
                     end else begin
                        tail_in  = ptr_up(tail_ff);
                        wr_en    = 1'b1;
                        wr_addr  = ptr_up(tail_ff);
                        back_in  = req_value;
                        cnt_in   = cnt_ff + 1'b1;
                     end
                  end
                  cdq_pkg::MODE_POP_FRONT, cdq_pkg::MODE_POP_BACK: begin
                     if (cnt_ff == '0) begin
                        rsp_fault_in = 1'b1;
                     end else begin
                        cnt_in = cnt_ff - 1'b1;
                        if (req_mode == cdq_pkg::MODE_POP_FRONT) begin
                           rsp_popped_in = front_ff;
                        end else begin
                           rsp_popped_in = back_ff;
                        end
                        if (cnt_ff == CW'(1)) begin
                           // deque drains: pointers go home
                           head_in = '0;
                           tail_in = '0;
                        end else if (req_mode == cdq_pkg::MODE_POP_FRONT) begin
                           head_in       = ptr_up(head_ff);
                           rd_en         = 1'b1;
                           rd_addr       = ptr_up(head_ff);
                           side_front_in = 1'b1;
                           rsp_valid_in  = 1'b0;
                           state_in      = ST_FILL;
                        end else begin
                           tail_in       = ptr_down(tail_ff);
                           rd_en         = 1'b1;
                           rd_addr       = ptr_down(tail_ff);
                           side_front_in = 1'b0;
                           rsp_valid_in  = 1'b0;
                           state_in      = ST_FILL;
                        end
                     end
                  end
                  default: begin
                     rsp_fault_in = 1'b0;
                  end
               endcase
               rsp_occ_in   = cnt_in;
               rsp_front_in = (cnt_in == '0) ? cdq_pkg::NEG_ONE : front_in;
               rsp_back_in  = (cnt_in == '0) ? cdq_pkg::NEG_ONE : back_in;
            end
         end
         ST_FILL: begin
            // new end element arrives from memory
            if (side_front_ff) begin
               front_in = rd_data;
            end else begin
               back_in = rd_data;
            end
            rsp_front_in = front_in;
            rsp_back_in  = back_in;
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State and response registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      front_ff      <= front_in;
      back_ff       <= back_in;
      side_front_ff <= side_front_in;
      rsp_popped_ff <= rsp_popped_in;
      rsp_front_ff  <= rsp_front_in;
      rsp_back_ff   <= rsp_back_in;
      rsp_occ_ff    <= rsp_occ_in;
      rsp_fault_ff  <= rsp_fault_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_popped_value = rsp_popped_ff;
   assign rsp_front_value  = rsp_front_ff;
   assign rsp_back_value   = rsp_back_ff;
   assign rsp_occupancy    = rsp_occ_ff;
   assign rsp_is_empty     = (rsp_occ_ff == '0);
   assign rsp_is_full      = (rsp_occ_ff == CntFull);
   assign rsp_fault        = rsp_fault_ff;

endmodule
